>>> src/kbq_pkg.sv
// Shared types and constants for the keyboard event queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package kbq_pkg;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 8;
   localparam int ACT_W   = 2;
   localparam int CP_W    = 21;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 10;
   localparam int DROP_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
   localparam logic [OP_W-1:0] OP_CHAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP   = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // key actions
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REPEAT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_ENA = 1'd1;

   typedef struct packed {
      logic accept;   // take the request beat and update state
      logic finish;   // memory data ready: form the result
   } kbq_cmd_type;

   typedef struct packed {
      logic out_full; // both result registers hold a beat
   } kbq_sts_type;

   typedef struct packed {
      logic               event_valid;
      logic [KEY_W-1:0]   event_code;
      logic [CP_W-1:0]    event_codepoint;
      logic               event_pressed;
      logic               event_autorep;
      logic [TIME_W-1:0]  event_time;
      logic               key_is_down;
      logic [COUNT_W-1:0] queue_count;
      logic [DROP_W-1:0]  drop_count;
   } kbq_rsp_type;

endpackage

>>> src/kbq_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on kbq_pkg for field widths.
interface kbq_req_if import kbq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [KEY_W-1:0]  key_code;
   logic [ACT_W-1:0]  action;
   logic [CP_W-1:0]   codepoint;
   logic [TIME_W-1:0] time_ns;

   modport source (output valid, op, key_code, action, codepoint, time_ns, input ready);
   modport sink   (input valid, op, key_code, action, codepoint, time_ns, output ready);
endinterface

interface kbq_rsp_if import kbq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               event_valid;
   logic [KEY_W-1:0]   event_code;
   logic [CP_W-1:0]    event_codepoint;
   logic               event_pressed;
   logic               event_autorep;
   logic [TIME_W-1:0]  event_time;
   logic               key_is_down;
   logic [COUNT_W-1:0] queue_count;
   logic [DROP_W-1:0]  drop_count;

   modport source (output valid, event_valid, event_code, event_codepoint, event_pressed,
                   event_autorep, event_time, key_is_down, queue_count, drop_count,
                   input ready);
   modport sink   (input valid, event_valid, event_code, event_codepoint, event_pressed,
                   event_autorep, event_time, key_is_down, queue_count, drop_count,
                   output ready);
endinterface

>>> src/kbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/kbq_ctrl.sv
// Controller for the keyboard event queue: two-state sequencer per request beat.
// Depends on kbq_pkg for the command and status structs.
module kbq_ctrl import kbq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kbq_sts_type sts,
   output kbq_cmd_type cmd
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_FETCH = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready  = (state_ff == S_IDLE) && !sts.out_full;
   assign cmd.accept = req_valid && req_ready;
   assign cmd.finish = (state_ff == S_FETCH);

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = cmd.accept ? S_FETCH : S_IDLE;
         S_FETCH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/kbq_dp.sv
// Datapath for the keyboard event queue: ring pointers, key map, event RAMs,
// result stage and two-entry output buffer. Depends on kbq_pkg and kbq_ram.
module kbq_dp import kbq_pkg::*; #(
   parameter int QUEUE_DEPTH = 1024,
   parameter int KEY_SLOTS   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kbq_cmd_type           cmd,
   output kbq_sts_type           sts,
   input  logic [OP_W-1:0]       req_op,
   input  logic [KEY_W-1:0]      req_key_code,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [CP_W-1:0]       req_codepoint,
   input  logic [TIME_W-1:0]     req_time_ns,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kbq_rsp_type           rsp_data
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int KW = $clog2(KEY_SLOTS);
   localparam logic [IW:0] DEPTH_W = (IW+1)'(QUEUE_DEPTH);
   localparam int INFO_W = KEY_W + 2;

   function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx);
      logic [IW:0] s;
      s = {1'b0, idx} + 1'b1;
      adv = (s >= DEPTH_W) ? '0 : s[IW-1:0];
   endfunction

   // configuration
   logic enable_ff, rep_ena_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         rep_ena_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff  <= csr_wr_data[0];
            CSR_REPEAT_ENA: rep_ena_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // ring and key state
   logic [IW-1:0]        rd_ff, rd_in, wr_ff, wr_in, pend_slot_ff, pend_slot_in;
   logic                 pend_valid_ff, pend_valid_in, drop_next_ff, drop_next_in;
   logic [KEY_SLOTS-1:0] key_map_ff, key_map_in;
   logic [DROP_W-1:0]    lost_ff, lost_in;

   logic [IW-1:0] rd_next, wr_next;
   logic [KW-1:0] key_idx;
   logic          key_in_range, key_pressed, key_rep;
   logic          push, attach, pop_hit, query_down;
   logic [KEY_W-1:0] push_key;
   logic [CP_W-1:0]  push_char;
   logic          push_pressed, push_rep;
   logic [IW:0]   wait_cnt;

   assign rd_next      = adv(rd_ff);
   assign wr_next      = adv(wr_ff);
   assign key_idx      = KW'(req_key_code);
   assign key_in_range = 32'(req_key_code) < KEY_SLOTS;
   assign key_pressed  = (req_action != ACT_RELEASE);
   assign key_rep      = (req_action == ACT_REPEAT);

   always_comb begin
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      pend_slot_in  = pend_slot_ff;
      pend_valid_in = pend_valid_ff;
      drop_next_in  = drop_next_ff;
      key_map_in    = key_map_ff;
      lost_in       = lost_ff;
      push          = 1'b0;
      attach        = 1'b0;
      pop_hit       = 1'b0;
      query_down    = 1'b0;
      push_key      = '0;
      push_char     = '0;
      push_pressed  = 1'b0;
      push_rep      = 1'b0;
      if (cmd.accept) begin
         unique case (req_op)
            OP_KEY: begin
               if (enable_ff) begin
                  drop_next_in = 1'b0;
                  if (key_in_range && (req_key_code != '0)) begin
                     key_map_in[key_idx] = key_pressed;
                  end
                  if (key_rep && !rep_ena_ff) begin
                     drop_next_in  = 1'b1;
                     pend_valid_in = 1'b0;
                  end else begin
                     push          = 1'b1;
                     push_key      = req_key_code;
                     push_pressed  = key_pressed;
                     push_rep      = key_rep;
                     pend_valid_in = key_pressed;
                  end
               end
            end
            OP_CHAR: begin
               if (enable_ff) begin
                  if (drop_next_ff) begin
                     drop_next_in = 1'b0;
                  end else if (pend_valid_ff) begin
                     attach        = 1'b1;
                     pend_valid_in = 1'b0;
                  end else begin
                     push          = 1'b1;
                     push_char     = req_codepoint;
                     push_pressed  = 1'b1;
                     pend_valid_in = 1'b0;
                  end
               end
            end
            OP_POP: begin
               if (rd_ff != wr_ff) begin
                  pop_hit = 1'b1;
                  rd_in   = rd_next;
               end
            end
            OP_QUERY: begin
               query_down = key_in_range && key_map_ff[key_idx];
            end
            default: ;
         endcase
         if (push) begin
            wr_in        = wr_next;
            pend_slot_in = wr_ff;
            // full ring: drop the oldest event
            if (wr_next == rd_ff) begin
               rd_in = rd_next;
               if (lost_ff != '1) begin
                  lost_in = lost_ff + 1'b1;
               end
            end
         end
      end
      wait_cnt = (wr_in >= rd_in) ? ({1'b0, wr_in} - {1'b0, rd_in})
                                  : (DEPTH_W - {1'b0, rd_in} + {1'b0, wr_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff         <= '0;
         wr_ff         <= '0;
         pend_slot_ff  <= '0;
         pend_valid_ff <= 1'b0;
         drop_next_ff  <= 1'b0;
         key_map_ff    <= '0;
         lost_ff       <= '0;
      end else begin
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         pend_slot_ff  <= pend_slot_in;
         pend_valid_ff <= pend_valid_in;
         drop_next_ff  <= drop_next_in;
         key_map_ff    <= key_map_in;
         lost_ff       <= lost_in;
      end
   end

   // event storage: key/flags, character and timestamp in separate RAMs
   logic [INFO_W-1:0] info_q;
   logic [CP_W-1:0]   char_q;
   logic [TIME_W-1:0] time_q;

   kbq_ram #(.WIDTH(INFO_W), .DEPTH(QUEUE_DEPTH)) u_info_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ff),
      .wr_data ({push_key, push_pressed, push_rep}),
      .rd_en   (cmd.accept),
      .rd_addr (rd_ff),
      .rd_data (info_q)
   );

   kbq_ram #(.WIDTH(CP_W), .DEPTH(QUEUE_DEPTH)) u_char_ram (
      .clock   (clock),
      .wr_en   (push || attach),
      .wr_addr (attach ? pend_slot_ff : wr_ff),
      .wr_data (attach ? req_codepoint : push_char),
      .rd_en   (cmd.accept),
      .rd_addr (rd_ff),
      .rd_data (char_q)
   );

   kbq_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ff),
      .wr_data (req_time_ns),
      .rd_en   (cmd.accept),
      .rd_addr (rd_ff),
      .rd_data (time_q)
   );

   // result stage: hold the step's scalar results until the RAM data is out
   logic               st_hit_ff, st_kd_ff;
   logic [COUNT_W-1:0] st_count_ff;
   logic [DROP_W-1:0]  st_drop_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         st_hit_ff   <= pop_hit;
         st_kd_ff    <= query_down;
         st_count_ff <= COUNT_W'(wait_cnt);
         st_drop_ff  <= lost_in;
      end
   end

   kbq_rsp_type res;

   always_comb begin
      res               = '0;
      res.event_valid   = st_hit_ff;
      if (st_hit_ff) begin
         res.event_code      = info_q[INFO_W-1:2];
         res.event_pressed   = info_q[1];
         res.event_autorep   = info_q[0];
         res.event_codepoint = char_q;
         res.event_time      = time_q;
      end
      res.key_is_down   = st_kd_ff;
      res.queue_count   = st_count_ff;
      res.drop_count    = st_drop_ff;
   end

   // two-entry output buffer: head register plus skid register
   logic        head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;
   kbq_rsp_type head_ff, head_in, skid_ff, skid_in;
   logic        head_free;

   assign head_free = !head_valid_ff || rsp_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (head_free) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = res;
            skid_valid_in = cmd.finish;
         end else begin
            head_in       = res;
            head_valid_in = cmd.finish;
         end
      end else if (cmd.finish) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign sts.out_full = skid_valid_ff;
   assign rsp_valid    = head_valid_ff;
   assign rsp_data     = head_ff;

endmodule

>>> src/keyboard_event_queue_core.sv
// Keyboard event queue, top level. Request beats carry an op (key event, character,
// pop, key-down query); every request returns exactly one response beat.
// Depends on kbq_pkg, kbq_if, kbq_ram, kbq_ctrl and kbq_dp.
//
// Channels: req_ch (sink) takes request beats, rsp_ch (source) gives response
// beats, both valid/ready. csr_* writes enable (index 0) and repeat enable
// (index 1); the user must write them only while the block is idle, as the
// block itself does not enforce it; there is no read-back.
// A response passes the event RAM read and result stage, then the output register
// (or the skid register while that one is held). No new request is taken while
// one is being finished: a request issues the RAM read, the finish forms the beat.
// Event storage is a ring of QUEUE_DEPTH slots holding at most QUEUE_DEPTH-1
// events; a push into a full ring overwrites the oldest and counts a drop.
// Reset: synchronous, clears pointers, key-down map, drop counter and both
// configuration bits. Event RAMs are not cleared; the ring never reads an
// unwritten slot, so no clearing pass is needed.
// Stall: two response registers sit on the output, so a new request is taken
// while one finished response waits; with both full, req_ch.ready drops.
module keyboard_event_queue_core import kbq_pkg::*; #(
   parameter int QUEUE_DEPTH = 1024,
   parameter int KEY_SLOTS   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   kbq_req_if.sink               req_ch,
   kbq_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   kbq_cmd_type cmd;
   kbq_sts_type sts;
   kbq_rsp_type rsp_data;
   logic        rsp_valid;

   // sequencer: accept a beat, then finish it in the following cycle
   kbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // ring, key map, event RAMs and output buffer
   kbq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KEY_SLOTS   (KEY_SLOTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_ch.op),
      .req_key_code  (req_ch.key_code),
      .req_action    (req_ch.action),
      .req_codepoint (req_ch.codepoint),
      .req_time_ns   (req_ch.time_ns),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data      (rsp_data)
   );

   // drive the response channel from the output register
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.event_valid     = rsp_data.event_valid;
   assign rsp_ch.event_code      = rsp_data.event_code;
   assign rsp_ch.event_codepoint = rsp_data.event_codepoint;
   assign rsp_ch.event_pressed   = rsp_data.event_pressed;
   assign rsp_ch.event_autorep   = rsp_data.event_autorep;
   assign rsp_ch.event_time      = rsp_data.event_time;
   assign rsp_ch.key_is_down     = rsp_data.key_is_down;
   assign rsp_ch.queue_count     = rsp_data.queue_count;
   assign rsp_ch.drop_count      = rsp_data.drop_count;

   // every accepted beat is finished in the following cycle
   a_accept_then_finish: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> cmd.finish)
      else $error("accepted request was not finished next cycle");

   // no new request is taken while one is being finished
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !req_ch.ready)
      else $error("request accepted during finish cycle");

   // a popped event and a key-down answer never share a response
   a_pop_excludes_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_valid) |-> !rsp_ch.key_is_down)
      else $error("pop response also reports key down");

   // the ring never reports more than depth minus one waiting events
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((QUEUE_DEPTH > 1024) || (rsp_ch.queue_count < QUEUE_DEPTH)))
      else $error("queue count exceeds ring capacity");

endmodule

>>> tb/sv/kbq_ring_mirror_pkg.sv
// Scoreboard for the keyboard event queue: a mirror of the event ring, the key-down
// map and the drop counter that predicts every response beat and checks the DUT's.
// Depends on kbq_pkg for field widths, op codes, register indexes and the response struct.
package kbq_ring_mirror_pkg;
   import kbq_pkg::*;

   localparam int RING_SLOTS    = 1 << COUNT_W;
   localparam int KEY_MAP_SLOTS = 1 << KEY_W;
   localparam int REPORT_LIMIT  = 10;

   // press has no name in kbq_pkg; the spare action code also acts as a press
   localparam logic [ACT_W-1:0] ACT_PRESS     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PRESS_ALT = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key_code;
      logic [ACT_W-1:0]  action;
      logic [CP_W-1:0]   codepoint;
      logic [TIME_W-1:0] time_ns;
   } kbq_req_beat_type;

   class kbq_ring_mirror;
      bit [KEY_W-1:0]   slot_key     [RING_SLOTS];
      bit [CP_W-1:0]    slot_char    [RING_SLOTS];
      bit               slot_pressed [RING_SLOTS];
      bit               slot_repeat  [RING_SLOTS];
      bit [TIME_W-1:0]  slot_stamp   [RING_SLOTS];
      bit               key_held     [KEY_MAP_SLOTS];
      bit [COUNT_W-1:0] rd_ptr, wr_ptr, attach_slot;
      bit               attach_open, swallow_char;
      bit [DROP_W-1:0]  lost;
      bit               active, repeats_on;
      kbq_rsp_type      awaited_responses [$];
      int               beats_checked;
      int               failures;

      function void set_register(logic [CSR_IDX_W-1:0] idx, bit value);
         case (idx)
            CSR_ENABLE:     active = value;
            CSR_REPEAT_ENA: repeats_on = value;
         endcase
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction

      function int failure_count();
         return failures;
      endfunction

      // full ring: drop the oldest, count it (saturating), then write
      function void push_event(bit [KEY_W-1:0] key, bit [CP_W-1:0] cp, bit pressed,
                               bit rep, bit [TIME_W-1:0] stamp);
         bit [COUNT_W-1:0] next_slot;
         next_slot = wr_ptr + 1'b1;
         if (next_slot == rd_ptr) begin
            rd_ptr++;
            if (lost != '1)
               lost++;
         end
         slot_key[wr_ptr]     = key;
         slot_char[wr_ptr]    = cp;
         slot_pressed[wr_ptr] = pressed;
         slot_repeat[wr_ptr]  = rep;
         slot_stamp[wr_ptr]   = stamp;
         attach_slot = wr_ptr;
         attach_open = pressed;
         wr_ptr = next_slot;
      endfunction

      function kbq_rsp_type response_for(kbq_req_beat_type b);
         kbq_rsp_type r;
         bit          pressed, rep;
         r = '0;
         case (b.op)
            OP_KEY: if (active) begin
               pressed = (b.action != ACT_RELEASE);
               rep = (b.action == ACT_REPEAT);
               swallow_char = 1'b0;
               if (b.key_code != '0)
                  key_held[b.key_code] = pressed;
               if (rep && !repeats_on) begin
                  swallow_char = 1'b1;
                  attach_open = 1'b0;
               end else begin
                  push_event(b.key_code, '0, pressed, rep, b.time_ns);
               end
            end
            OP_CHAR: if (active) begin
               if (swallow_char) begin
                  swallow_char = 1'b0;
               end else if (attach_open) begin
                  // may land in a slot already popped; then it is never seen
                  slot_char[attach_slot] = b.codepoint;
                  attach_open = 1'b0;
               end else begin
                  push_event('0, b.codepoint, 1'b1, 1'b0, b.time_ns);
                  attach_open = 1'b0;
               end
            end
            OP_POP: if (rd_ptr != wr_ptr) begin
               r.event_valid     = 1'b1;
               r.event_code      = slot_key[rd_ptr];
               r.event_codepoint = slot_char[rd_ptr];
               r.event_pressed   = slot_pressed[rd_ptr];
               r.event_autorep   = slot_repeat[rd_ptr];
               r.event_time      = slot_stamp[rd_ptr];
               rd_ptr++;
            end
            OP_QUERY: r.key_is_down = key_held[b.key_code];
         endcase
         r.queue_count = wr_ptr - rd_ptr;
         r.drop_count  = lost;
         return r;
      endfunction

      function void note_request(kbq_req_beat_type b);
         awaited_responses.push_back(response_for(b));
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want)
            report($sformatf("beat %0d %s: expected %h, got %h",
                             beats_checked, name, want, got));
      endfunction

      function void check_response(kbq_rsp_type got);
         kbq_rsp_type want;
         if (awaited_responses.size() == 0) begin
            report($sformatf("beat %0d arrived with nothing outstanding: %h",
                             beats_checked, got));
            beats_checked++;
            return;
         end
         want = awaited_responses.pop_front();
         compare_field("event_valid", want.event_valid, got.event_valid);
         compare_field("event_code", want.event_code, got.event_code);
         compare_field("event_codepoint", want.event_codepoint, got.event_codepoint);
         compare_field("event_pressed", want.event_pressed, got.event_pressed);
         compare_field("event_autorep", want.event_autorep, got.event_autorep);
         compare_field("event_time", want.event_time, got.event_time);
         compare_field("key_is_down", want.key_is_down, got.key_is_down);
         compare_field("queue_count", want.queue_count, got.queue_count);
         compare_field("drop_count", want.drop_count, got.drop_count);
         beats_checked++;
      endfunction
   endclass

endpackage

>>> tb/sv/testbench.sv
// Top level of the keyboard event queue testbench: clock, reset, request and response
// drivers, register writes, directed and random stimulus, watchdog and verdict.
// Depends on kbq_pkg, kbq_if, kbq_ring_mirror_pkg and keyboard_event_queue_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kbq_pkg::*;
   import kbq_ring_mirror_pkg::*;

   // cycles without any beat moving before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   // settle time after the last response
   localparam int DRAIN_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    burst_left;
   int                    phase_beats;
   int                    idle_cycles;

   kbq_req_if      req_bus ();
   kbq_rsp_if      rsp_bus ();
   kbq_ring_mirror ring_mirror = new();

   keyboard_event_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: alternate ready-high runs with short stalls; now and then hold
   // ready high for a long stretch so back-to-back beats get through.
   initial begin
      int hold_high;
      int hold_low;
      rsp_bus.ready = 1'b0;
      forever begin
         hold_high = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
         hold_low  = $urandom_range(1, 5);
         repeat (hold_high) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
         repeat (hold_low) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   // Sample each accepted response beat at the rising edge and check it.
   always @(posedge clock) begin
      kbq_rsp_type beat;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         beat.event_valid     = rsp_bus.event_valid;
         beat.event_code      = rsp_bus.event_code;
         beat.event_codepoint = rsp_bus.event_codepoint;
         beat.event_pressed   = rsp_bus.event_pressed;
         beat.event_autorep   = rsp_bus.event_autorep;
         beat.event_time      = rsp_bus.event_time;
         beat.key_is_down     = rsp_bus.key_is_down;
         beat.queue_count     = rsp_bus.queue_count;
         beat.drop_count      = rsp_bus.drop_count;
         ring_mirror.check_response(beat);
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic [TIME_W-1:0] random_stamp();
      return {$urandom(), $urandom()};
   endfunction

   // mostly real code points; sometimes all 21 bits at random
   function automatic logic [CP_W-1:0] random_codepoint();
      if (chance(80))
         return CP_W'($urandom_range(32, 21'h10FFFF));
      return CP_W'($urandom());
   endfunction

   // the unknown code shows up now and then
   function automatic logic [KEY_W-1:0] random_key();
      if ($urandom_range(0, 15) == 0)
         return '0;
      return KEY_W'($urandom_range(1, KEY_MAP_SLOTS - 1));
   endfunction

   function automatic logic [ACT_W-1:0] press_action();
      return ($urandom_range(0, 7) == 0) ? ACT_PRESS_ALT : ACT_PRESS;
   endfunction

   function automatic kbq_req_beat_type beat_of(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [ACT_W-1:0] act,
                                                input logic [CP_W-1:0] cp,
                                                input logic [TIME_W-1:0] stamp);
      kbq_req_beat_type b;
      b.op        = op;
      b.key_code  = key;
      b.action    = act;
      b.codepoint = cp;
      b.time_ns   = stamp;
      return b;
   endfunction

   // every field random, including ops and actions outside any sequence
   function automatic kbq_req_beat_type noise_beat();
      return beat_of(OP_W'($urandom_range(OP_KEY, OP_QUERY)), KEY_W'($urandom()),
                     ACT_W'($urandom_range(ACT_PRESS, ACT_PRESS_ALT)),
                     CP_W'($urandom()), random_stamp());
   endfunction

   // Send one request beat. Entered and left at a falling edge. At the start
   // of a burst, drop valid for a random gap (sometimes none), then hold the
   // beat until the block takes it.
   task automatic issue(input kbq_req_beat_type beat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.op        <= beat.op;
      req_bus.key_code  <= beat.key_code;
      req_bus.action    <= beat.action;
      req_bus.codepoint <= beat.codepoint;
      req_bus.time_ns   <= beat.time_ns;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ring_mirror.note_request(beat);
      phase_beats++;
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding response is back, then let
   // the block settle.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (ring_mirror.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write both registers while the block is idle.
   task automatic configure(input bit enable_on, input bit repeat_on);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ENABLE;
      csr_wr_data <= enable_on;
      @(negedge clock);
      csr_index   <= CSR_REPEAT_ENA;
      csr_wr_data <= repeat_on;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      ring_mirror.set_register(CSR_ENABLE, enable_on);
      ring_mirror.set_register(CSR_REPEAT_ENA, repeat_on);
   endtask

   // One keystroke: press, optional character, auto-repeats each with an
   // optional character, optional query, release, optional trailing
   // character, then a run of pops and maybe a noise beat.
   task automatic type_keystroke(input int char_pct, input int repeat_max,
                                 input int query_pct, input int tail_char_pct,
                                 input int pop_pct, input int noise_pct);
      logic [KEY_W-1:0] key;
      int               repeats;
      key = random_key();
      repeats = $urandom_range(0, repeat_max);
      issue(beat_of(OP_KEY, key, press_action(), random_codepoint(), random_stamp()));
      if (chance(char_pct))
         issue(beat_of(OP_CHAR, random_key(), press_action(), random_codepoint(),
                       random_stamp()));
      repeat (repeats) begin
         issue(beat_of(OP_KEY, key, ACT_REPEAT, random_codepoint(), random_stamp()));
         if (chance(char_pct))
            issue(beat_of(OP_CHAR, key, ACT_REPEAT, random_codepoint(), random_stamp()));
      end
      if (chance(query_pct))
         issue(beat_of(OP_QUERY, key, press_action(), random_codepoint(), random_stamp()));
      issue(beat_of(OP_KEY, key, ACT_RELEASE, random_codepoint(), random_stamp()));
      if (chance(tail_char_pct))
         issue(beat_of(OP_CHAR, key, ACT_RELEASE, random_codepoint(), random_stamp()));
      while (chance(pop_pct))
         issue(beat_of(OP_POP, random_key(), press_action(), random_codepoint(),
                       random_stamp()));
      if (chance(noise_pct))
         issue(noise_beat());
   endtask

   task automatic run_keystrokes(input int beats, input int char_pct, input int repeat_max,
                                 input int query_pct, input int tail_char_pct,
                                 input int pop_pct, input int noise_pct);
      phase_beats = 0;
      while (phase_beats < beats)
         type_keystroke(char_pct, repeat_max, query_pct, tail_char_pct, pop_pct, noise_pct);
   endtask

   task automatic run_noise(input int beats);
      phase_beats = 0;
      while (phase_beats < beats)
         issue(noise_beat());
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_KEY;
      req_bus.key_code  = '0;
      req_bus.action    = ACT_PRESS;
      req_bus.codepoint = '0;
      req_bus.time_ns   = '0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_ENABLE;
      csr_wr_data       = '0;
      burst_left        = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, repeats on: empty pop with every field at its top value,
      // extremes of key, code point and time, the unknown key, the spare
      // press code, a queued repeat taking a character, a character after a
      // release, and a character attached to an event already popped.
      configure(1'b1, 1'b1);
      issue(beat_of(OP_POP, '1, ACT_PRESS_ALT, '1, '1));
      issue(beat_of(OP_QUERY, '1, ACT_PRESS, '0, '0));
      issue(beat_of(OP_KEY, '1, ACT_PRESS, '0, '1));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, '1, '0));
      issue(beat_of(OP_KEY, '0, ACT_PRESS_ALT, '1, '0));
      issue(beat_of(OP_QUERY, '0, ACT_PRESS, '0, '0));
      issue(beat_of(OP_QUERY, '1, ACT_PRESS, '0, '0));
      issue(beat_of(OP_KEY, '1, ACT_REPEAT, '0, random_stamp()));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, CP_W'('h61), random_stamp()));
      issue(beat_of(OP_KEY, '1, ACT_RELEASE, '0, random_stamp()));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, CP_W'('h10FFFF), random_stamp()));
      repeat (5) issue(beat_of(OP_POP, '0, ACT_PRESS, '0, '0));
      issue(beat_of(OP_KEY, KEY_W'('h41), ACT_PRESS, '0, random_stamp()));
      issue(beat_of(OP_POP, '0, ACT_PRESS, '0, '0));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, CP_W'('h42), random_stamp()));
      issue(beat_of(OP_POP, '0, ACT_PRESS, '0, '0));
      issue(beat_of(OP_QUERY, KEY_W'('h41), ACT_PRESS, '0, '0));

      // Directed, repeats off: a swallowed repeat eats the next character,
      // and a key beat in between cancels the swallow.
      configure(1'b1, 1'b0);
      issue(beat_of(OP_KEY, KEY_W'('h41), ACT_REPEAT, '0, random_stamp()));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, CP_W'('h43), random_stamp()));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, CP_W'('h44), random_stamp()));
      issue(beat_of(OP_KEY, KEY_W'('h42), ACT_REPEAT, '0, random_stamp()));
      issue(beat_of(OP_KEY, KEY_W'('h42), ACT_RELEASE, '0, random_stamp()));
      issue(beat_of(OP_CHAR, '0, ACT_PRESS, CP_W'('h45), random_stamp()));
      repeat (2) issue(beat_of(OP_POP, '0, ACT_PRESS, '0, '0));

      // Random typing with repeats queued, then with repeats suppressed.
      configure(1'b1, 1'b1);
      run_keystrokes(220, 70, 3, 25, 40, 45, 10);
      configure(1'b1, 1'b0);
      run_keystrokes(220, 60, 3, 25, 40, 45, 10);

      // Fill: every beat pushes and nothing pops, so the ring wraps and
      // overwrites its oldest events.
      run_keystrokes(1100, 0, 0, 0, 100, 0, 0);

      // Pop-heavy typing with repeats on, starting from a full ring.
      configure(1'b1, 1'b1);
      run_keystrokes(250, 50, 2, 25, 40, 90, 10);

      // Disabled: key and character beats are ignored, pops and queries work.
      configure(1'b0, 1'b1);
      run_noise(80);

      drain_responses();
      if (ring_mirror.failure_count() == 0 && ring_mirror.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
src/kbq_pkg.sv
src/kbq_if.sv
src/kbq_ram.sv
src/kbq_ctrl.sv
src/kbq_dp.sv
src/keyboard_event_queue_core.sv
tb/sv/kbq_ring_mirror_pkg.sv
tb/sv/testbench.sv
